// ===== rtl/u8dw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_pkg: shared types and constants of the utf-8 width decoder
// Holds the work item passed from the decode front to the emit back, the
// replacement codepoint and the column width lookup.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int TOTAL_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // one decoded byte: some replacements, then at most one final result
  typedef struct packed {
    logic [1:0]  n_repl;      // leading replacements for held bytes
    logic        has_final;   // a final result follows the replacements
    logic [20:0] final_cp;
    logic [1:0]  final_width;
    logic [2:0]  final_used;
    logic        final_repl;
    logic        eot;         // byte closed the string
  } cmd_t;

  // terminal column width of a codepoint
  function automatic logic [1:0] col_width(input logic [20:0] cp);
    logic [1:0] w;
    w = 2'd1;
    if ((cp >= 21'h01F300 && cp <= 21'h01FAFF) ||
        (cp >= 21'h002E80 && cp <= 21'h00A4CF) ||
        (cp >= 21'h00AC00 && cp <= 21'h00D7AF) ||
        (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
        (cp >= 21'h00FF00 && cp <= 21'h00FF60) ||
        (cp >= 21'h00FE10 && cp <= 21'h00FE1F) ||
        (cp >= 21'h00FE30 && cp <= 21'h00FE6F) ||
        (cp >= 21'h001100 && cp <= 21'h00115F)) begin
      w = 2'd2;
    end else if (cp == 21'h00200D || (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
                 (cp >= 21'h00FE00 && cp <= 21'h00FE0F)) begin
      w = 2'd0;
    end
    return w;
  endfunction

endpackage

// ===== rtl/u8dw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_in_if: byte input channel
// Valid/ready channel carrying one text byte and its end-of-string mark.
// ----------------------------------------------------------------------------
interface u8dw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

// ===== rtl/u8dw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_out_if: result output channel
// Valid/ready channel carrying one decoded codepoint and its width data.
// ----------------------------------------------------------------------------
interface u8dw_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  column_width;
  logic [2:0]  bytes_used;
  logic        replaced;
  logic [15:0] running_width;
  logic        last_in_run;
  logic        text_done;

  modport source (output valid, code_point, column_width, bytes_used, replaced,
                  running_width, last_in_run, text_done, input ready);
  modport sink   (input valid, code_point, column_width, bytes_used, replaced,
                  running_width, last_in_run, text_done, output ready);
endinterface

// ===== rtl/u8dw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_front: utf-8 sequence tracker
// Takes one byte per cycle while the queue has room, tracks the pending
// multi-byte sequence and pushes a work item for each byte causing results.
// ----------------------------------------------------------------------------
module u8dw_front (
  input  logic            clk,
  input  logic            rst,
  u8dw_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            cmd_push,
  output u8dw_pkg::cmd_t  cmd
);
  import u8dw_pkg::*;

  logic [2:0]  needed;
  logic [1:0]  held;
  logic [20:0] partial;
  logic [2:0]  needed_next;
  logic [1:0]  held_next;
  logic [20:0] partial_next;

  logic        accept;
  logic        pending;
  logic        is_cont;
  logic [2:0]  held_inc;
  logic        complete;
  logic [20:0] partial_ext;
  logic        lead_ascii;
  logic        lead_bad;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pending     = (needed != 3'd0);
  assign is_cont     = (in_ch.data_byte[7:6] == 2'b10);
  assign held_inc    = {1'b0, held} + 3'd1;
  assign complete    = (held_inc >= needed);
  assign partial_ext = {partial[14:0], in_ch.data_byte[5:0]};

  // lead byte classification
  always_comb begin
    lead_ascii = 1'b0;
    lead_bad   = 1'b0;
    lead_len   = 3'd0;
    lead_bits  = '0;
    if (!in_ch.data_byte[7]) begin
      lead_ascii = 1'b1;
    end else if (in_ch.data_byte[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, in_ch.data_byte[4:0]};
    end else if (in_ch.data_byte[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, in_ch.data_byte[3:0]};
    end else if (in_ch.data_byte[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, in_ch.data_byte[2:0]};
    end else begin
      lead_bad = 1'b1;
    end
  end

  // per-byte decision: work item and next sequence state
  always_comb begin
    cmd          = '0;
    cmd.eot      = in_ch.end_of_text;
    cmd_push     = 1'b0;
    needed_next  = needed;
    held_next    = held;
    partial_next = partial;
    if (accept) begin
      if (pending && is_cont) begin
        if (complete) begin
          cmd.has_final   = 1'b1;
          cmd.final_cp    = partial_ext;
          cmd.final_width = col_width(partial_ext);
          cmd.final_used  = needed;
          cmd_push        = 1'b1;
          needed_next     = '0;
          held_next       = '0;
          partial_next    = '0;
        end else if (in_ch.end_of_text) begin
          cmd.n_repl = held_inc[1:0];
          cmd_push   = 1'b1;
        end else begin
          held_next    = held_inc[1:0];
          partial_next = partial_ext;
        end
      end else begin
        // flush any held bytes, then treat this byte as a lead
        cmd.n_repl   = pending ? held : 2'd0;
        needed_next  = '0;
        held_next    = '0;
        partial_next = '0;
        if (lead_ascii) begin
          cmd.has_final   = 1'b1;
          cmd.final_cp    = {13'd0, in_ch.data_byte};
          cmd.final_width = col_width({13'd0, in_ch.data_byte});
          cmd.final_used  = 3'd1;
        end else if (lead_bad || in_ch.end_of_text) begin
          cmd.has_final   = 1'b1;
          cmd.final_cp    = REPL_CP;
          cmd.final_width = 2'd1;
          cmd.final_used  = 3'd1;
          cmd.final_repl  = 1'b1;
        end else begin
          needed_next  = lead_len;
          held_next    = 2'd1;
          partial_next = lead_bits;
        end
        cmd_push = cmd.has_final || (cmd.n_repl != 2'd0);
      end
      if (in_ch.end_of_text) begin
        needed_next  = '0;
        held_next    = '0;
        partial_next = '0;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      needed  <= '0;
      held    <= '0;
      partial <= '0;
    end else begin
      needed  <= needed_next;
      held    <= held_next;
      partial <= partial_next;
    end
  end

  // a pending sequence always holds its lead and is not yet complete
  a_pending_held: assert property (@(posedge clk) disable iff (rst)
    pending |-> (held != 2'd0) && ({1'b0, held} < needed))
    else $error("pending sequence with inconsistent held count");

  // an end-of-text byte always produces results
  a_eot_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_text |-> cmd_push)
    else $error("end-of-text byte gave no results");

endmodule

// ===== rtl/u8dw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_queue: work item queue
// Short first-in first-out buffer between the decode front and the emit back.
// ----------------------------------------------------------------------------
module u8dw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8dw_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8dw_pkg::cmd_t  head_cmd
);
  import u8dw_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end
  end

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ===== rtl/u8dw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dw_back: result emitter
// Expands each work item into its results, one per cycle unless stalled,
// keeps the saturating width sum and drives the registered output channel.
// ----------------------------------------------------------------------------
module u8dw_back #(
  parameter int TOTAL_BITS = u8dw_pkg::TOTAL_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  u8dw_pkg::cmd_t  head_cmd,
  output logic            pop,
  u8dw_out_if.source      out_ch
);
  import u8dw_pkg::*;

  logic [1:0]            idx;
  logic [TOTAL_BITS-1:0] sum;
  logic                  out_valid;
  logic [20:0]           out_cp;
  logic [1:0]            out_width;
  logic [2:0]            out_used;
  logic                  out_repl;
  logic [15:0]           out_sum;
  logic                  out_last;
  logic                  out_done;

  logic                  load;
  logic                  repl_step;
  logic                  last_of_cmd;
  logic [1:0]            idx_inc;
  logic [20:0]           cur_cp;
  logic [1:0]            cur_width;
  logic [2:0]            cur_used;
  logic                  cur_repl;
  logic [TOTAL_BITS:0]   sum_ext;
  logic [TOTAL_BITS-1:0] sum_sat;

  assign load      = head_valid && (!out_valid || out_ch.ready);
  assign idx_inc   = idx + 2'd1;
  assign repl_step = (idx < head_cmd.n_repl);
  assign last_of_cmd = repl_step ? ((idx_inc == head_cmd.n_repl) && !head_cmd.has_final)
                                 : 1'b1;
  assign pop       = load && last_of_cmd;

  // select the current result of the head item
  always_comb begin
    if (repl_step) begin
      cur_cp    = REPL_CP;
      cur_width = 2'd1;
      cur_used  = 3'd1;
      cur_repl  = 1'b1;
    end else begin
      cur_cp    = head_cmd.final_cp;
      cur_width = head_cmd.final_width;
      cur_used  = head_cmd.final_used;
      cur_repl  = head_cmd.final_repl;
    end
  end

  // saturating width sum
  assign sum_ext = {1'b0, sum} + (TOTAL_BITS + 1)'(cur_width);
  assign sum_sat = sum_ext[TOTAL_BITS] ? '1 : sum_ext[TOTAL_BITS-1:0];

  // output register, step index and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      sum       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_of_cmd ? 2'd0 : idx_inc;
        sum       <= (last_of_cmd && head_cmd.eot) ? '0 : sum_sat;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp    <= cur_cp;
      out_width <= cur_width;
      out_used  <= cur_used;
      out_repl  <= cur_repl;
      out_sum   <= 16'(sum_sat);
      out_last  <= last_of_cmd;
      out_done  <= last_of_cmd && head_cmd.eot;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.code_point    = out_cp;
  assign out_ch.column_width  = out_width;
  assign out_ch.bytes_used    = out_used;
  assign out_ch.replaced      = out_repl;
  assign out_ch.running_width = out_sum;
  assign out_ch.last_in_run   = out_last;
  assign out_ch.text_done     = out_done;

  // step index stays within the replacements of the head item
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head_cmd.n_repl)
    else $error("step index beyond head item");

  // the sum restarts after the final result of a string
  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    load && last_of_cmd && head_cmd.eot |=> sum == '0)
    else $error("width sum not cleared at end of string");

  // end of string is only flagged on the last result of a byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("text_done without last_in_run");

endmodule

// ===== rtl/utf8_decode_display_width.sv =====
`timescale 1ns / 1ps
// path: an accepted byte's work item is written into the item queue, and the
//   back expands the queue head into results held in the output register
// throughput: one byte per cycle in while the queue has room, one result per
//   cycle out while the receiver is ready; a byte has up to 4 results on errors,
//   and the four-entry item queue between front and back absorbs such bursts
// reset: clears the sequence state, the queue, the width sum and output valid
// ----------------------------------------------------------------------------
// utf8_decode_display_width: utf-8 decoder with terminal column width
// Decodes a byte stream into codepoints with column width, byte count,
// replacement flag and a saturating running width per string.
// ----------------------------------------------------------------------------
module utf8_decode_display_width #(
  parameter int TOTAL_BITS = u8dw_pkg::TOTAL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  u8dw_in_if.sink     in_ch,
  u8dw_out_if.source  out_ch
);
  import u8dw_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  u8dw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  u8dw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  u8dw_back #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: utf-8 decoder with terminal column width
// Drives bytes through the input channel and checks every decoded codepoint
// against an in-bench decoder model or a written-out expectation. A short
// table of directed bytes comes first (extremes, all sequence lengths, bad
// bytes, truncation, the four result burst), then a short string with a
// zero-width joiner, then mostly well-formed random text mixed with stray and
// broken sequences. Both channels idle at random, the receiver holds off once
// for a long stretch, and the sender pauses until the block drains.
// ----------------------------------------------------------------------------
module testbench;

  localparam int    TB_TOTAL_BITS = u8dw_pkg::TOTAL_BITS_DEF;
  localparam longint WIDTH_LIMIT  = (64'd1 << TB_TOTAL_BITS) - 64'd1;
  localparam int    MAX_RESULTS   = 4;
  localparam int    RANDOM_ITEMS  = 320;
  localparam int    LONG_HOLD     = 300;
  localparam int    DRAIN_CYCLES  = 16;
  localparam int    MAX_REPORTS   = 50;
  localparam longint CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  cols;
    logic [2:0]  used;
    logic        repl;
    logic [15:0] run;
    logic        last;
    logic        done;
  } cp_result_t;

  typedef struct {
    logic [7:0] data;
    logic       eot;
    bit         known;
    cp_result_t res;
  } text_row_t;

  logic clk;
  logic rst;

  u8dw_in_if  byte_ch ();
  u8dw_out_if cp_ch ();

  utf8_decode_display_width #(
    .TOTAL_BITS(TB_TOTAL_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (byte_ch),
    .out_ch(cp_ch)
  );

  // decoder model state
  logic [2:0]  pend_len;
  logic [1:0]  pend_held;
  logic [20:0] pend_code;
  longint      width_total;

  cp_result_t step_results[$];
  cp_result_t expected_cps[$];
  text_row_t  text_rows[$];
  logic [7:0] chunk[$];

  int     mismatches = 0;
  int     reports = 0;
  longint cycles = 0;
  bit     calm;
  int     hold_asked;
  int     hold_granted;
  int     hold_left;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // terminal columns of a codepoint
  function automatic logic [1:0] columns_of(input logic [20:0] cp);
    if ((cp >= 21'h1F300 && cp <= 21'h1FAFF) || (cp >= 21'h02E80 && cp <= 21'h0A4CF) ||
        (cp >= 21'h0AC00 && cp <= 21'h0D7AF) || (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
        (cp >= 21'h0FF00 && cp <= 21'h0FF60) || (cp >= 21'h0FE10 && cp <= 21'h0FE1F) ||
        (cp >= 21'h0FE30 && cp <= 21'h0FE6F) || (cp >= 21'h01100 && cp <= 21'h0115F))
      return 2'd2;
    if (cp == 21'h0200D || (cp >= 21'h020D0 && cp <= 21'h020FF) ||
        (cp >= 21'h0FE00 && cp <= 21'h0FE0F))
      return 2'd0;
    return 2'd1;
  endfunction

  // append one codepoint, advancing the saturating width sum
  task automatic add_result(input logic [20:0] cp, input logic [2:0] used, input logic repl);
    cp_result_t r;
    logic [1:0] w;
    if (step_results.size() >= MAX_RESULTS) return;
    w = columns_of(cp);
    if (width_total >= WIDTH_LIMIT || WIDTH_LIMIT - width_total < w) width_total = WIDTH_LIMIT;
    else width_total = width_total + w;
    r.cp   = cp;
    r.cols = w;
    r.used = used;
    r.repl = repl;
    r.run  = width_total[15:0];
    r.last = 1'b0;
    r.done = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic clear_sequence();
    pend_len  = 3'd0;
    pend_held = 2'd0;
    pend_code = 21'd0;
  endtask

  // one replacement per held byte
  task automatic flush_held();
    for (int k = 0; k < pend_held; k++) add_result(u8dw_pkg::REPL_CP, 3'd1, 1'b1);
    clear_sequence();
  endtask

  // byte seen with no sequence pending
  task automatic start_sequence(input logic [7:0] b, input logic eot);
    logic [2:0]  len;
    logic [20:0] bits;
    if (b[7] == 1'b0) begin
      add_result({13'd0, b}, 3'd1, 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) begin
      len  = 3'd2;
      bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      len  = 3'd3;
      bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      len  = 3'd4;
      bits = {18'd0, b[2:0]};
    end else begin
      add_result(u8dw_pkg::REPL_CP, 3'd1, 1'b1);
      return;
    end
    if (eot) begin
      add_result(u8dw_pkg::REPL_CP, 3'd1, 1'b1);
      return;
    end
    pend_len  = len;
    pend_held = 2'd1;
    pend_code = bits;
  endtask

  // results caused by one accepted byte, left in step_results
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [2:0]  done_len;
    logic [20:0] done_cp;
    step_results.delete();
    if (pend_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        pend_code = {pend_code[14:0], b[5:0]};
        pend_held = pend_held + 2'd1;
        if (pend_held == 2'd0 || pend_held >= pend_len) begin
          done_len = pend_len;
          done_cp  = pend_code;
          clear_sequence();
          add_result(done_cp, done_len, 1'b0);
        end else if (eot) begin
          flush_held();
        end
      end else begin
        flush_held();
        start_sequence(b, eot);
      end
    end else begin
      start_sequence(b, eot);
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
      if (eot) step_results[step_results.size() - 1].done = 1'b1;
    end
    if (eot) begin
      width_total = 0;
      clear_sequence();
    end
  endtask

  // queue one expected codepoint
  task automatic expect_cp(input cp_result_t r);
    expected_cps.insert(expected_cps.size(), r);
  endtask

  // offer one item; on acceptance queue its expected codepoints
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit known,
                           input cp_result_t known_res);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.end_of_text <= eot;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, eot);
    if (known) expect_cp(known_res);
    else foreach (step_results[i]) expect_cp(step_results[i]);
  endtask

  // stop offering and let every expected codepoint come out
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic eot);
    text_row_t r;
    r.data  = b;
    r.eot   = eot;
    r.known = 1'b0;
    r.res   = '0;
    text_rows.insert(text_rows.size(), r);
  endtask

  // single-result row with its expectation written out
  task automatic add_known(input logic [7:0] b, input logic eot, input logic [20:0] cp,
                           input logic repl, input logic [15:0] run);
    text_row_t r;
    r.data  = b;
    r.eot   = eot;
    r.known = 1'b1;
    r.res   = '{cp: cp, cols: 2'd1, used: 3'd1, repl: repl, run: run, last: 1'b1, done: eot};
    text_rows.insert(text_rows.size(), r);
  endtask

  // one more byte of random text
  task automatic chunk_add(input logic [7:0] b);
    chunk.insert(chunk.size(), b);
  endtask

  // utf-8 bytes of cp in a sequence of the given length
  task automatic encode_cp(input logic [20:0] cp, input int len);
    case (len)
      1: chunk_add({1'b0, cp[6:0]});
      2: begin
        chunk_add({3'b110, cp[10:6]});
        chunk_add({2'b10, cp[5:0]});
      end
      3: begin
        chunk_add({4'b1110, cp[15:12]});
        chunk_add({2'b10, cp[11:6]});
        chunk_add({2'b10, cp[5:0]});
      end
      default: begin
        chunk_add({5'b11110, cp[20:18]});
        chunk_add({2'b10, cp[17:12]});
        chunk_add({2'b10, cp[11:6]});
        chunk_add({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // codepoint on or next to a width range edge, or inside the range
  function automatic logic [20:0] pick_edge_cp();
    logic [20:0] lo;
    logic [20:0] hi;
    case ($urandom_range(0, 10))
      0:       begin lo = 21'h01100; hi = 21'h0115F; end
      1:       begin lo = 21'h02E80; hi = 21'h0A4CF; end
      2:       begin lo = 21'h0AC00; hi = 21'h0D7AF; end
      3:       begin lo = 21'h0F900; hi = 21'h0FAFF; end
      4:       begin lo = 21'h0FE10; hi = 21'h0FE1F; end
      5:       begin lo = 21'h0FE30; hi = 21'h0FE6F; end
      6:       begin lo = 21'h0FF00; hi = 21'h0FF60; end
      7:       begin lo = 21'h1F300; hi = 21'h1FAFF; end
      8:       begin lo = 21'h0200D; hi = 21'h0200D; end
      9:       begin lo = 21'h020D0; hi = 21'h020FF; end
      default: begin lo = 21'h0FE00; hi = 21'h0FE0F; end
    endcase
    case ($urandom_range(0, 4))
      0:       return lo - 21'd1;
      1:       return lo;
      2:       return hi;
      3:       return hi + 21'd1;
      default: return 21'($urandom_range(lo, hi));
    endcase
  endfunction

  // next piece of random text into chunk
  task automatic build_chunk();
    int          sel;
    int          len;
    int          keep;
    logic [20:0] cp;
    chunk.delete();
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      // well-formed character
      if ($urandom_range(0, 9) < 4) begin
        cp = pick_edge_cp();
      end else begin
        case ($urandom_range(0, 3))
          0:       cp = 21'($urandom_range(0, 'h7F));
          1:       cp = 21'($urandom_range('h80, 'h7FF));
          2:       cp = 21'($urandom_range('h800, 'hFFFF));
          default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
        endcase
      end
      encode_cp(cp, natural_len(cp));
    end else if (sel < 80) begin
      // stray byte
      chunk_add(8'($urandom_range(0, 255)));
    end else begin
      // sequence cut short, optionally followed by a non-continuation byte
      len  = $urandom_range(2, 4);
      keep = $urandom_range(1, len - 1);
      encode_cp(21'($urandom), len);
      while (chunk.size() > keep) void'(chunk.pop_back());
      if (sel >= 90) begin
        if ($urandom_range(0, 1) == 0) chunk_add(8'($urandom_range(0, 127)));
        else chunk_add(8'($urandom_range(192, 255)));
      end
    end
  endtask

  // result checking
  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    cp_result_t exp_r;
    if (!rst && cp_ch.valid && cp_ch.ready) begin
      if (expected_cps.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected codepoint, expected none, actual 0x%0h", $time,
                   cp_ch.code_point);
        end
      end else begin
        exp_r = expected_cps.pop_front();
        check_field("code_point", exp_r.cp, cp_ch.code_point);
        check_field("column_width", exp_r.cols, cp_ch.column_width);
        check_field("bytes_used", exp_r.used, cp_ch.bytes_used);
        check_field("replaced", exp_r.repl, cp_ch.replaced);
        check_field("running_width", exp_r.run, cp_ch.running_width);
        check_field("last_in_run", exp_r.last, cp_ch.last_in_run);
        check_field("text_done", exp_r.done, cp_ch.text_done);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    cp_ch.ready  = 1'b0;
    hold_granted = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        cp_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_granted != hold_asked) begin
        hold_granted = hold_granted + 1;
        hold_left    = LONG_HOLD - 1;
        cp_ch.ready <= 1'b0;
      end else begin
        cp_ch.ready <= (calm || $urandom_range(0, 99) >= 33);
      end
    end
  end

  // stimulus
  initial begin
    int         sent;
    logic       eot;
    cp_result_t no_res;
    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'd0;
    byte_ch.end_of_text = 1'b0;
    calm        = 1'b0;
    hold_asked  = 0;
    no_res      = '0;
    width_total = 0;
    clear_sequence();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: extremes, bad leads, every length, bursts, truncation
    add_known(8'h00, 1'b0, 21'h00000, 1'b0, 16'd1);
    add_known(8'h7F, 1'b0, 21'h0007F, 1'b0, 16'd2);
    add_known(8'h80, 1'b0, u8dw_pkg::REPL_CP, 1'b1, 16'd3);
    add_known(8'hFF, 1'b0, u8dw_pkg::REPL_CP, 1'b1, 16'd4);
    add_known(8'hF8, 1'b1, u8dw_pkg::REPL_CP, 1'b1, 16'd5);
    add_row(8'hC2, 1'b0); add_row(8'hA9, 1'b0);
    add_row(8'hF0, 1'b0); add_row(8'h9F, 1'b0); add_row(8'h98, 1'b0); add_row(8'h80, 1'b0);
    add_row(8'hEF, 1'b0); add_row(8'hB8, 1'b0); add_row(8'h8F, 1'b0);
    // three held bytes broken by an invalid lead: four results
    add_row(8'hF0, 1'b0); add_row(8'h9F, 1'b0); add_row(8'h98, 1'b0); add_row(8'hFF, 1'b0);
    // largest codepoint
    add_row(8'hF7, 1'b0); add_row(8'hBF, 1'b0); add_row(8'hBF, 1'b0); add_row(8'hBF, 1'b0);
    // string ends on a continuation, then on a lone lead
    add_row(8'hE0, 1'b0); add_row(8'h80, 1'b1);
    add_row(8'hC3, 1'b1);
    foreach (text_rows[i]) send_byte(text_rows[i].data, text_rows[i].eot, text_rows[i].known,
                                     text_rows[i].res);
    drain();

    // wide character, zero-width joiner, then plain letters closing the string
    calm = 1'b1;
    send_byte(8'hE4, 1'b0, 1'b0, no_res);
    send_byte(8'hB8, 1'b0, 1'b0, no_res);
    send_byte(8'h80, 1'b0, 1'b0, no_res);
    send_byte(8'hE2, 1'b0, 1'b0, no_res);
    send_byte(8'h80, 1'b0, 1'b0, no_res);
    send_byte(8'h8D, 1'b0, 1'b0, no_res);
    send_byte(8'h41, 1'b0, 1'b0, no_res);
    send_byte(8'h42, 1'b1, 1'b0, no_res);
    calm = 1'b0;
    drain();

    // random text
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_chunk();
      foreach (chunk[i]) begin
        if (sent == 60) hold_asked = hold_asked + 1;
        calm = (sent >= 150 && sent < 230);
        eot  = ($urandom_range(0, 99) < 6);
        send_byte(chunk[i], eot, 1'b0, no_res);
        sent++;
      end
    end
    calm = 1'b0;
    send_byte(8'h2E, 1'b1, 1'b0, no_res);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
